// ----- rtl/spgr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_pkg
// Shared types, constants and register codes of the step/direction pulse
// generator with linear ramp.
// ----------------------------------------------------------------------------
package spgr_pkg;

  // Command store and step counter sizing.
  localparam int QDEPTH    = 8;
  localparam int STEP_BITS = 20;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Fixed field widths.
  localparam int PULSE_W = 16;
  localparam int DELAY_W = 16;
  localparam int LEVEL_W = 4;
  localparam int CNT_W   = DELAY_W + 1;
  localparam int HALF_W  = DELAY_W - 1;
  localparam int DPROD_W = HALF_W + STEP_BITS;
  localparam int IT_W    = $clog2(HALF_W + 1);

  // Ramp length rules.
  localparam int MIN_RAMP_STEPS = 4;
  localparam int RAMP_DIV       = 10;
  localparam int MIN_RAMP_LEN   = 2;

  // steps / RAMP_DIV is taken as (steps * RECIP_M) >> RECIP_SH, exact for all
  // step counts of STEP_BITS bits.
  localparam int RECIP_SH = STEP_BITS + 4;
  localparam longint unsigned RECIP_M =
    ((64'd1 << RECIP_SH) + 64'(RAMP_DIV - 1)) / 64'(RAMP_DIV);
  localparam int RECIP_W = RECIP_SH - 3;
  localparam int RPROD_W = STEP_BITS + RECIP_W;

  // Depth of the item queue and of the result queue.
  localparam int IQ_DEPTH = 2;
  localparam int IQP_W    = (IQ_DEPTH > 1) ? $clog2(IQ_DEPTH) : 1;
  localparam int IQC_W    = $clog2(IQ_DEPTH + 1);

  // Motion phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Request types.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_CMD  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_PULSE_HIGH = 2'd0;
  localparam logic [1:0] REG_BASE_DELAY = 2'd1;
  localparam logic [1:0] REG_EN_ACT_LOW = 2'd2;
  localparam logic [1:0] REG_INV_DIR    = 2'd3;

  typedef logic [STEP_BITS-1:0] steps_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [HALF_W-1:0]    quo_t;
  typedef logic [DPROD_W-1:0]   dprod_t;
  typedef logic [RECIP_W-1:0]   recip_t;
  typedef logic [RPROD_W-1:0]   rprod_t;
  typedef logic [QPTR_W-1:0]    qptr_t;
  typedef logic [QCNT_W-1:0]    qcnt_t;
  typedef logic [QCNT_W:0]      tsum_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [IT_W-1:0]      it_t;
  typedef logic [IQP_W-1:0]     iqptr_t;
  typedef logic [IQC_W-1:0]     iqcnt_t;

  typedef struct packed {
    logic   req_type;
    steps_t step_count;
    logic   clockwise;
    logic   ramp_on;
    logic   release_at_end;
    logic   notify_at_end;
  } in_item_t;

  typedef struct packed {
    logic   step_out;
    logic   dir_out;
    logic   enable_out;
    logic   moving;
    logic   done_event;
    logic   cmd_dropped;
    level_t queue_level;
  } out_item_t;

  // A move command as it is kept in the command store.
  typedef struct packed {
    logic   notify;
    logic   rel_end;
    logic   ramp_on;
    logic   clockwise;
    steps_t steps;
  } cmd_t;

  // An item after classification by the front end.
  typedef struct packed {
    logic is_cmd;
    cmd_t cmd;
  } item_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_high_ticks;
    logic [DELAY_W-1:0] base_step_delay;
    logic               en_pol_low;
    logic               invert_dir;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/spgr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_front
// Input side: accepts items, classifies them as ticks or move commands and
// holds them in a short queue for the motion engine.
// ----------------------------------------------------------------------------
module spgr_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire spgr_pkg::in_item_t  in_data,
  output logic                     item_valid,
  output spgr_pkg::item_t          item,
  input  wire logic                item_pop
);

  spgr_pkg::item_t  mem_r [spgr_pkg::IQ_DEPTH];
  spgr_pkg::iqptr_t wp_r, wp_nxt;
  spgr_pkg::iqptr_t rp_r, rp_nxt;
  spgr_pkg::iqcnt_t cnt_r, cnt_nxt;
  spgr_pkg::item_t  cls;
  logic             wr_en;
  logic             rd_en;

  always_comb begin
    cls.is_cmd        = (in_data.req_type == spgr_pkg::REQ_CMD);
    cls.cmd.notify    = in_data.notify_at_end;
    cls.cmd.rel_end   = in_data.release_at_end;
    cls.cmd.ramp_on   = in_data.ramp_on;
    cls.cmd.clockwise = in_data.clockwise;
    cls.cmd.steps     = in_data.step_count;
  end

  assign full       = (cnt_r == spgr_pkg::iqcnt_t'(spgr_pkg::IQ_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rp_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_pop && item_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == spgr_pkg::iqptr_t'(spgr_pkg::IQ_DEPTH - 1)) ? '0
             : wp_r + spgr_pkg::iqptr_t'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == spgr_pkg::iqptr_t'(spgr_pkg::IQ_DEPTH - 1)) ? '0
             : rp_r + spgr_pkg::iqptr_t'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + spgr_pkg::iqcnt_t'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - spgr_pkg::iqcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spgr_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_div
// Restoring divider for the ramp extension, one quotient bit per cycle.
// The quotient is known to fit HALF_W bits, so only that many steps run.
// ----------------------------------------------------------------------------
module spgr_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire spgr_pkg::dprod_t dividend,
  input  wire spgr_pkg::steps_t divisor,
  output logic                  done,
  output spgr_pkg::quo_t        quot
);

  spgr_pkg::steps_t            rem_r, rem_nxt;
  spgr_pkg::quo_t              low_r, low_nxt;
  spgr_pkg::quo_t              q_r, q_nxt;
  spgr_pkg::it_t               it_r, it_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [spgr_pkg::STEP_BITS:0] trial;
  logic [spgr_pkg::STEP_BITS:0] diff;
  logic                        qbit;

  assign done = done_r;
  assign quot = q_r;

  always_comb begin
    trial    = {rem_r, low_r[spgr_pkg::HALF_W-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    it_nxt   = it_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = spgr_pkg::steps_t'(dividend >> spgr_pkg::HALF_W);
      low_nxt  = dividend[spgr_pkg::HALF_W-1:0];
      q_nxt    = '0;
      it_nxt   = spgr_pkg::it_t'(spgr_pkg::HALF_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[spgr_pkg::STEP_BITS-1:0] : trial[spgr_pkg::STEP_BITS-1:0];
      low_nxt = low_r << 1;
      q_nxt   = {q_r[spgr_pkg::HALF_W-2:0], qbit};
      it_nxt  = it_r - spgr_pkg::it_t'(1);
      if (it_r == spgr_pkg::it_t'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/spgr_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_engine
// Back end: keeps the command store and the motion state, carries out one
// classified item at a time and hands one result per item to the result queue.
// ----------------------------------------------------------------------------
module spgr_engine (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire spgr_pkg::cfg_t   cfg,
  input  wire logic             item_valid,
  input  wire spgr_pkg::item_t  item,
  output logic                  item_pop,
  input  wire logic             res_space,
  output logic                  res_push,
  output spgr_pkg::out_item_t   res_data,
  output logic                  div_start,
  output spgr_pkg::dprod_t      div_dividend,
  output spgr_pkg::steps_t      div_divisor,
  input  wire logic             div_done,
  input  wire spgr_pkg::quo_t   div_quot
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RMUL   = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_DELTA  = 4'd3;
  localparam logic [3:0] ST_DMUL   = 4'd4;
  localparam logic [3:0] ST_DIVS   = 4'd5;
  localparam logic [3:0] ST_DIVW   = 4'd6;
  localparam logic [3:0] ST_LOWSET = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  spgr_pkg::cmd_t   cq_r [spgr_pkg::QDEPTH];
  spgr_pkg::cmd_t   act_r;
  logic [3:0]       st_r, st_nxt;
  spgr_pkg::qptr_t  head_r, head_nxt;
  spgr_pkg::qcnt_t  count_r, count_nxt;
  spgr_pkg::steps_t idx_r, idx_nxt;
  spgr_pkg::steps_t rlen_r, rlen_nxt;
  spgr_pkg::steps_t delta_r, delta_nxt;
  logic [1:0]       phase_r, phase_nxt;
  spgr_pkg::cnt_t   cnt_r, cnt_nxt;
  logic             step_r, step_nxt;
  logic             dir_r, dir_nxt;
  logic             en_r, en_nxt;
  logic             done_r, done_nxt;
  logic             drop_r, drop_nxt;
  spgr_pkg::rprod_t rprod_r, rprod_nxt;
  spgr_pkg::dprod_t dprod_r, dprod_nxt;

  logic             cq_we;
  logic             act_ld;
  spgr_pkg::tsum_t  tail_sum;
  spgr_pkg::qptr_t  tail;
  spgr_pkg::cnt_t   pulse_len;
  spgr_pkg::cnt_t   cnt_dec;
  spgr_pkg::steps_t idx_inc;
  spgr_pkg::steps_t r10;
  spgr_pkg::steps_t half_steps;
  spgr_pkg::steps_t rclamp;
  spgr_pkg::steps_t steps_left;
  spgr_pkg::quo_t   half_base;
  spgr_pkg::quo_t   ext;
  spgr_pkg::cnt_t   low_len;

  always_comb begin
    tail_sum = spgr_pkg::tsum_t'(head_r) + spgr_pkg::tsum_t'(count_r);
    if (tail_sum >= spgr_pkg::tsum_t'(spgr_pkg::QDEPTH)) begin
      tail = spgr_pkg::qptr_t'(tail_sum - spgr_pkg::tsum_t'(spgr_pkg::QDEPTH));
    end else begin
      tail = spgr_pkg::qptr_t'(tail_sum);
    end
    pulse_len  = (cfg.pulse_high_ticks == '0) ? spgr_pkg::cnt_t'(1)
               : spgr_pkg::cnt_t'(cfg.pulse_high_ticks);
    cnt_dec    = (cnt_r != '0) ? cnt_r - spgr_pkg::cnt_t'(1) : cnt_r;
    idx_inc    = idx_r + spgr_pkg::steps_t'(1);
    r10        = spgr_pkg::steps_t'(rprod_r >> spgr_pkg::RECIP_SH);
    half_steps = act_r.steps >> 1;
    rclamp     = (r10 < spgr_pkg::steps_t'(spgr_pkg::MIN_RAMP_LEN))
               ? spgr_pkg::steps_t'(spgr_pkg::MIN_RAMP_LEN) : r10;
    if (rclamp > half_steps) begin
      rclamp = half_steps;
    end
    steps_left = act_r.steps - idx_r;
    half_base  = spgr_pkg::quo_t'(cfg.base_step_delay >> 1);
    // A zero ramp length leaves the base delay unchanged.
    ext        = (rlen_r == '0) ? '0 : div_quot;
    low_len    = spgr_pkg::cnt_t'(cfg.base_step_delay) + spgr_pkg::cnt_t'(ext);
  end

  assign div_dividend = dprod_r;
  assign div_divisor  = rlen_r;

  always_comb begin
    res_data.step_out    = step_r;
    res_data.dir_out     = dir_r;
    res_data.enable_out  = en_r;
    res_data.moving      = (phase_r != spgr_pkg::PH_IDLE);
    res_data.done_event  = done_r;
    res_data.cmd_dropped = drop_r;
    res_data.queue_level = spgr_pkg::level_t'(count_r);
  end

  always_comb begin
    st_nxt    = st_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    rlen_nxt  = rlen_r;
    delta_nxt = delta_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    en_nxt    = en_r;
    done_nxt  = done_r;
    drop_nxt  = drop_r;
    rprod_nxt = rprod_r;
    dprod_nxt = dprod_r;
    cq_we     = 1'b0;
    act_ld    = 1'b0;
    item_pop  = 1'b0;
    res_push  = 1'b0;
    div_start = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (item_valid && res_space) begin
          item_pop = 1'b1;
          done_nxt = 1'b0;
          drop_nxt = 1'b0;
          st_nxt   = ST_EMIT;
          if (item.is_cmd) begin
            if (count_r < spgr_pkg::qcnt_t'(spgr_pkg::QDEPTH)) begin
              cq_we     = 1'b1;
              count_nxt = count_r + spgr_pkg::qcnt_t'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (phase_r == spgr_pkg::PH_IDLE) begin
            if (count_r != '0) begin
              act_ld    = 1'b1;
              head_nxt  = (head_r == spgr_pkg::qptr_t'(spgr_pkg::QDEPTH - 1)) ? '0
                        : head_r + spgr_pkg::qptr_t'(1);
              count_nxt = count_r - spgr_pkg::qcnt_t'(1);
              en_nxt    = !cfg.en_pol_low;
              step_nxt  = 1'b0;
              idx_nxt   = '0;
              rlen_nxt  = '0;
              st_nxt    = ST_RMUL;
            end
          end else begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == '0) begin
              if (phase_r == spgr_pkg::PH_HIGH) begin
                st_nxt = ST_DELTA;
              end else begin
                idx_nxt = idx_inc;
                if (idx_inc >= act_r.steps) begin
                  phase_nxt = spgr_pkg::PH_IDLE;
                  cnt_nxt   = '0;
                  step_nxt  = 1'b0;
                  if (act_r.rel_end) begin
                    en_nxt = cfg.en_pol_low;
                  end
                  done_nxt = act_r.notify;
                end else begin
                  step_nxt  = 1'b1;
                  phase_nxt = spgr_pkg::PH_HIGH;
                  cnt_nxt   = pulse_len;
                end
              end
            end
          end
        end
      end
      ST_RMUL: begin
        rprod_nxt = spgr_pkg::rprod_t'(act_r.steps)
                  * spgr_pkg::rprod_t'(spgr_pkg::recip_t'(spgr_pkg::RECIP_M));
        dir_nxt   = act_r.clockwise ^ cfg.invert_dir;
        st_nxt    = ST_START;
      end
      ST_START: begin
        if (act_r.ramp_on &&
            act_r.steps >= spgr_pkg::steps_t'(spgr_pkg::MIN_RAMP_STEPS)) begin
          rlen_nxt = rclamp;
        end
        if (act_r.steps == '0) begin
          // An empty move starts and ends on the same tick.
          phase_nxt = spgr_pkg::PH_IDLE;
          cnt_nxt   = '0;
          step_nxt  = 1'b0;
          if (act_r.rel_end) begin
            en_nxt = cfg.en_pol_low;
          end
          done_nxt = act_r.notify;
        end else begin
          step_nxt  = 1'b1;
          phase_nxt = spgr_pkg::PH_HIGH;
          cnt_nxt   = pulse_len;
        end
        st_nxt = ST_EMIT;
      end
      ST_DELTA: begin
        if (idx_r < rlen_r) begin
          delta_nxt = rlen_r - idx_r;
        end else if (steps_left <= rlen_r) begin
          delta_nxt = rlen_r - steps_left;
        end else begin
          delta_nxt = '0;
        end
        st_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        dprod_nxt = spgr_pkg::dprod_t'(half_base) * spgr_pkg::dprod_t'(delta_r);
        st_nxt    = ST_DIVS;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        st_nxt    = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          st_nxt = ST_LOWSET;
        end
      end
      ST_LOWSET: begin
        step_nxt  = 1'b0;
        phase_nxt = spgr_pkg::PH_LOW;
        cnt_nxt   = (low_len == '0) ? spgr_pkg::cnt_t'(1) : low_len;
        st_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        res_push = 1'b1;
        st_nxt   = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      rlen_r  <= '0;
      phase_r <= spgr_pkg::PH_IDLE;
      cnt_r   <= '0;
      step_r  <= 1'b0;
      dir_r   <= 1'b0;
      en_r    <= 1'b1;
      done_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      rlen_r  <= rlen_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
      done_r  <= done_nxt;
      drop_r  <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    rprod_r <= rprod_nxt;
    dprod_r <= dprod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (act_ld) begin
      act_r <= cq_r[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cq_we) begin
      cq_r[tail] <= item.cmd;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spgr_outq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_outq
// Result queue: holds finished result items until the consumer pops them.
// ----------------------------------------------------------------------------
module spgr_outq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 res_push,
  input  wire spgr_pkg::out_item_t  res_data,
  output logic                      res_space,
  output logic                      empty,
  input  wire logic                 pop,
  output spgr_pkg::out_item_t       out_data
);

  spgr_pkg::out_item_t mem_r [spgr_pkg::IQ_DEPTH];
  spgr_pkg::iqptr_t    wp_r, wp_nxt;
  spgr_pkg::iqptr_t    rp_r, rp_nxt;
  spgr_pkg::iqcnt_t    cnt_r, cnt_nxt;
  logic                wr_en;
  logic                rd_en;

  assign res_space = (cnt_r != spgr_pkg::iqcnt_t'(spgr_pkg::IQ_DEPTH));
  assign empty     = (cnt_r == '0);
  assign out_data  = mem_r[rp_r];
  assign wr_en     = res_push && res_space;
  assign rd_en     = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == spgr_pkg::iqptr_t'(spgr_pkg::IQ_DEPTH - 1)) ? '0
             : wp_r + spgr_pkg::iqptr_t'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == spgr_pkg::iqptr_t'(spgr_pkg::IQ_DEPTH - 1)) ? '0
             : rp_r + spgr_pkg::iqptr_t'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + spgr_pkg::iqcnt_t'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - spgr_pkg::iqcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= res_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stepper_pulse_generator_ramp.sv -----
// Once accepted, a command item or a tick that does not end a high phase goes
// to EMIT; a tick that starts a move goes through RMUL, START and EMIT; a tick
// that ends a high phase goes through DELTA, DMUL, DIVS, DIVW (ramp divider),
// LOWSET and EMIT. The motion engine works on one item at a time and takes no
// new item while the result queue is full. Reset (rst_n low, synchronous)
// empties both queues and the command store, idles the motor.
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_pulse_generator_ramp
// Step/direction pulse generator with linear ramp for one motor: item queue,
// motion engine with ramp divider, result queue and configuration registers.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_ramp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire spgr_pkg::in_item_t   in_data,
  output logic                      empty,
  input  wire logic                 pop,
  output spgr_pkg::out_item_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  spgr_pkg::cfg_t      cfg_r;
  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                item_valid;
  spgr_pkg::item_t     item;
  logic                item_pop;
  logic                res_space;
  logic                res_push;
  spgr_pkg::out_item_t res_data;
  logic                div_start;
  spgr_pkg::dprod_t    div_dividend;
  spgr_pkg::steps_t    div_divisor;
  logic                div_done;
  spgr_pkg::quo_t      div_quot;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_high_ticks <= spgr_pkg::PULSE_W'(2);
      cfg_r.base_step_delay  <= spgr_pkg::DELAY_W'(1000);
      cfg_r.en_pol_low       <= 1'b1;
      cfg_r.invert_dir       <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        spgr_pkg::REG_PULSE_HIGH: cfg_r.pulse_high_ticks <= pwdata[spgr_pkg::PULSE_W-1:0];
        spgr_pkg::REG_BASE_DELAY: cfg_r.base_step_delay  <= pwdata[spgr_pkg::DELAY_W-1:0];
        spgr_pkg::REG_EN_ACT_LOW: cfg_r.en_pol_low       <= pwdata[0];
        spgr_pkg::REG_INV_DIR:    cfg_r.invert_dir       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      spgr_pkg::REG_PULSE_HIGH: prdata = 32'(cfg_r.pulse_high_ticks);
      spgr_pkg::REG_BASE_DELAY: prdata = 32'(cfg_r.base_step_delay);
      spgr_pkg::REG_EN_ACT_LOW: prdata = 32'(cfg_r.en_pol_low);
      spgr_pkg::REG_INV_DIR:    prdata = 32'(cfg_r.invert_dir);
      default:                  prdata = '0;
    endcase
  end

  spgr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  spgr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  spgr_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .res_space    (res_space),
    .res_push     (res_push),
    .res_data     (res_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot)
  );

  spgr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_space (res_space),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/spgr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spgr_checker
// Port-level checks of the pulse generator, bound to the top level.
// ----------------------------------------------------------------------------
module spgr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                full,
  input wire logic                empty,
  input wire spgr_pkg::out_item_t out_data
);

  // Reset leaves no result pending and room for input.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A refused command is only reported with the command store full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.cmd_dropped) |->
      (out_data.queue_level == spgr_pkg::level_t'(spgr_pkg::QDEPTH)))
    else $error("command dropped with room in the store");

  // A completed move reports no motion on the same item.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.done_event) |-> (!out_data.moving && !out_data.cmd_dropped))
    else $error("done reported while moving or with a drop");

  // The step pin is high only during a move.
  a_step_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.step_out) |-> out_data.moving)
    else $error("step pin high while idle");

endmodule

bind stepper_pulse_generator_ramp spgr_checker u_spgr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .out_data (out_data)
);
`default_nettype wire
